@@ hdl/kvt_pkg.sv @@
// Package with the shared types and constants of the compacting key/value table.
`default_nettype none

package kvt_pkg;

  localparam int KEY_BITS    = 16;
  localparam int VALUE_BITS  = 32;
  localparam int CAP_BITS    = 5;
  localparam int COUNT_BITS  = 5;
  localparam int DEPTH_DEF   = 16;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_DEL = 2'd1,
    OP_UPD = 2'd2,
    OP_GET = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_ADD_DUP  = 3'd2,
    ST_GET_MISS = 3'd3,
    ST_DEL_MISS = 3'd4,
    ST_UPD_MISS = 3'd5,
    ST_UPD_DUP  = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_SCAN  = 2'd1,
    S_APPLY = 2'd2
  } state_e;

  typedef struct packed {
    op_e                   op;
    logic [KEY_BITS-1:0]   key;
    logic [KEY_BITS-1:0]   new_key;
    logic [VALUE_BITS-1:0] value;
  } in_t;

  typedef struct packed {
    status_e               status;
    logic [VALUE_BITS-1:0] read_value;
    logic [COUNT_BITS-1:0] entry_count;
  } out_t;

  typedef struct packed {
    logic                  vld;
    logic                  found;
    logic                  clash;
    logic [VALUE_BITS-1:0] rdval;
  } tok_t;

  typedef struct packed {
    logic                  add;
    logic                  upd;
    logic                  del;
    logic [KEY_BITS-1:0]   key;
    logic [KEY_BITS-1:0]   new_key;
    logic [VALUE_BITS-1:0] value;
  } cmd_t;

endpackage

`default_nettype wire

@@ hdl/kvt_cell.sv @@
// One table slot: holds an entry, checks the passing search token and shifts on delete.
`default_nettype none

module kvt_cell (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire kvt_pkg::cmd_t                 cmd,
  input  wire logic                          live,
  input  wire logic                          live_next,
  input  wire logic                          add_here,
  input  wire logic [kvt_pkg::KEY_BITS-1:0]   key_next,
  input  wire logic [kvt_pkg::VALUE_BITS-1:0] value_next,
  input  wire kvt_pkg::tok_t                 tok_in,
  output kvt_pkg::tok_t                      tok_out,
  output logic [kvt_pkg::KEY_BITS-1:0]        key,
  output logic [kvt_pkg::VALUE_BITS-1:0]      value
);

  logic          match;
  logic          first;
  logic          clash_here;
  logic          hit;
  logic          past;
  kvt_pkg::tok_t tok_next;

  always_comb begin
    match      = live && (key == cmd.key);
    first      = match && !tok_in.found;
    clash_here = live && (key == cmd.new_key) && (key != cmd.key);
    tok_next.vld   = tok_in.vld;
    tok_next.found = tok_in.found || match;
    tok_next.clash = tok_in.clash || clash_here;
    tok_next.rdval = first ? value : tok_in.rdval;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.vld <= 1'b0;
    end else begin
      tok_out.vld <= tok_next.vld;
    end
    tok_out.found <= tok_next.found;
    tok_out.clash <= tok_next.clash;
    tok_out.rdval <= tok_next.rdval;
    if (tok_in.vld) begin
      hit  <= first;
      past <= tok_next.found;
    end
    if (cmd.add && add_here) begin
      key   <= cmd.key;
      value <= cmd.value;
    end else if (cmd.upd && hit) begin
      key   <= cmd.new_key;
      value <= cmd.value;
    end else if (cmd.del && past && live_next) begin
      key   <= key_next;
      value <= value_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/compacting_key_value_table.sv @@
// Top level of the compacting key/value table: control, cell row and result register.
// An item passes the start flag, each cell's token register and res before the output.
// A new input is taken only in the idle state, once the previous item has been applied.
// A new input transfer is taken while the previous result still waits at the output.
// Reset clears the entry count, the control state and sets capacity to 16.
// Stored entries are not cleared; slots at or above the count are never read.
`default_nettype none

module compacting_key_value_table #(
  parameter int DEPTH = kvt_pkg::DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire kvt_pkg::in_t                  in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output kvt_pkg::out_t                      out_data,
  input  wire logic                          cfg_we,
  input  wire logic [kvt_pkg::CAP_BITS-1:0]   cfg_wdata
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > kvt_pkg::CAP_BITS) ? CW : kvt_pkg::CAP_BITS;

  kvt_pkg::state_e               state;
  kvt_pkg::state_e               state_next;
  logic [kvt_pkg::CAP_BITS-1:0]   capacity;
  logic [CW-1:0]                 count;
  logic [CW-1:0]                 count_next;
  logic                          start;
  kvt_pkg::in_t                  q;
  kvt_pkg::tok_t                 res;
  kvt_pkg::cmd_t                 cmd;
  kvt_pkg::status_e              status;
  logic [kvt_pkg::VALUE_BITS-1:0] rd;
  logic                          commit;
  logic                          full;

  kvt_pkg::tok_t                 tok [DEPTH+1];
  logic [kvt_pkg::KEY_BITS-1:0]   key_a [DEPTH];
  logic [kvt_pkg::VALUE_BITS-1:0] value_a [DEPTH];
  logic [DEPTH-1:0]              live;
  logic [DEPTH-1:0]              add_here;

  assign in_ready = (state == kvt_pkg::S_IDLE);

  assign tok[0] = '{vld: start, found: 1'b0, clash: 1'b0, rdval: '0};

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    localparam int NX = (g == DEPTH - 1) ? g : g + 1;
    logic live_nx;

    assign live[g]     = (count > CW'(g));
    assign add_here[g] = (count == CW'(g));
    assign live_nx     = (g == DEPTH - 1) ? 1'b0 : live[NX];

    kvt_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .live       (live[g]),
      .live_next  (live_nx),
      .add_here   (add_here[g]),
      .key_next   (key_a[NX]),
      .value_next (value_a[NX]),
      .tok_in     (tok[g]),
      .tok_out    (tok[g+1]),
      .key        (key_a[g]),
      .value      (value_a[g])
    );
  end

  always_comb begin
    full = (count >= CW'(DEPTH)) || (LW'(count) >= LW'(capacity));
    commit = (state == kvt_pkg::S_APPLY) && (!out_valid || out_ready);
    status = kvt_pkg::ST_OK;
    rd = '0;
    count_next = count;
    cmd.add = 1'b0;
    cmd.upd = 1'b0;
    cmd.del = 1'b0;
    cmd.key = q.key;
    cmd.new_key = q.new_key;
    cmd.value = q.value;
    case (q.op)
      kvt_pkg::OP_ADD: begin
        if (full) begin
          status = kvt_pkg::ST_FULL;
        end else if (res.found) begin
          status = kvt_pkg::ST_ADD_DUP;
        end else begin
          cmd.add = commit;
          count_next = count + 1'b1;
        end
      end
      kvt_pkg::OP_DEL: begin
        if (!res.found) begin
          status = kvt_pkg::ST_DEL_MISS;
        end else begin
          cmd.del = commit;
          count_next = count - 1'b1;
        end
      end
      kvt_pkg::OP_UPD: begin
        if (res.clash) begin
          status = kvt_pkg::ST_UPD_DUP;
        end else if (!res.found) begin
          status = kvt_pkg::ST_UPD_MISS;
        end else begin
          cmd.upd = commit;
        end
      end
      kvt_pkg::OP_GET: begin
        if (!res.found) begin
          status = kvt_pkg::ST_GET_MISS;
        end else begin
          rd = res.rdval;
        end
      end
      default: begin
        status = kvt_pkg::ST_OK;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      kvt_pkg::S_IDLE: begin
        if (in_valid) state_next = kvt_pkg::S_SCAN;
      end
      kvt_pkg::S_SCAN: begin
        if (tok[DEPTH].vld) state_next = kvt_pkg::S_APPLY;
      end
      kvt_pkg::S_APPLY: begin
        if (commit) state_next = kvt_pkg::S_IDLE;
      end
      default: begin
        state_next = kvt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= kvt_pkg::S_IDLE;
      capacity  <= kvt_pkg::CAP_RESET;
      count     <= '0;
      start     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      start <= in_valid && in_ready;
      if (cfg_we) capacity <= cfg_wdata;
      if (commit) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) q <= in_data;
    if (state == kvt_pkg::S_SCAN && tok[DEPTH].vld) res <= tok[DEPTH];
    if (commit) begin
      out_data.status      <= status;
      out_data.read_value  <= rd;
      out_data.entry_count <= kvt_pkg::COUNT_BITS'(count_next);
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_count_change: assert property (@(posedge clk) disable iff (rst)
    !$stable(count) |-> $past(state) == kvt_pkg::S_APPLY)
    else $error("entry count changed outside of the apply step");

  a_token_scan: assert property (@(posedge clk) disable iff (rst)
    tok[DEPTH].vld |-> state == kvt_pkg::S_SCAN)
    else $error("search token arrived outside of the scan");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == kvt_pkg::S_APPLY)
    else $error("result appeared without an apply step");

endmodule

`default_nettype wire
